// ===== rtl/code_data_flag_logger_macros.svh =====
// ----------------------------------------------------------------------------
// code_data_flag_logger assertion macros
// Clocked property checks, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CODE_DATA_FLAG_LOGGER_MACROS_SVH
`define CODE_DATA_FLAG_LOGGER_MACROS_SVH

`ifndef SYNTH
`define CDFL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("cdfl assertion failed");
`define CDFL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("cdfl assertion failed");
`else
`define CDFL_ASSERT(lbl, clk, rstn, prop)
`define CDFL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/cdfl_pkg.sv =====
// ----------------------------------------------------------------------------
// cdfl_pkg
// Shared widths, flag bit positions, opcodes and control structs.
// ----------------------------------------------------------------------------
package cdfl_pkg;

  localparam int ADDR_W = 24;
  localparam int FLAG_W = 8;
  localparam int OP_W   = 2;
  localparam int SIZE_W = 17;
  localparam int TOT_W  = 17;
  localparam int MODE_W = 2;

  localparam int ENTRIES_DEF = 65536;
  localparam logic [SIZE_W-1:0] ROM_SIZE_RST = SIZE_W'(65536);

  localparam int FL_CODE_B = 0;
  localparam int FL_DATA_B = 1;
  localparam int FL_JUMP_B = 2;
  localparam int FL_SUB_B  = 3;
  localparam int FL_IDX8_B = 4;
  localparam int FL_MEM8_B = 5;

  // data and mode bits dropped when an entry becomes code
  localparam logic [FLAG_W-1:0] CODE_KEEP = 8'hCD;

  typedef enum logic [OP_W-1:0] {
    OP_MERGE = 2'd0,
    OP_QUERY = 2'd1,
    OP_RAW   = 2'd2
  } cdfl_op_e;

  typedef struct packed {
    logic rd;   // transfer accepted, read entry
    logic clr;  // clearing pass write
    logic wb;   // write back and load result
  } cdfl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } cdfl_sts_t;

endpackage

// ===== rtl/cdfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdfl_ctrl
// Sequencer: clearing pass, accept, write-back and result valid.
// ----------------------------------------------------------------------------
`include "code_data_flag_logger_macros.svh"

module cdfl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  cdfl_pkg::cdfl_sts_t sts_i,
  output cdfl_pkg::cdfl_cmd_t cmd_o
);
  import cdfl_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WB
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q;
  logic        out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o.rd  = in_valid_i && (state_q == ST_IDLE);
    cmd_o.clr = (state_q == ST_CLEAR);
    cmd_o.wb  = (state_q == ST_WB) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_o.rd) state_d = ST_WB;
      end
      ST_WB: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.wb) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `CDFL_ASSERT(a_rd_to_wb, clk_i, rst_ni, cmd_o.rd |=> state_q == ST_WB)
  `CDFL_ASSERT(a_wb_valid, clk_i, rst_ni, cmd_o.wb |=> out_valid_q)
  `CDFL_ASSERT(a_cmd_excl, clk_i, rst_ni, $onehot0({cmd_o.rd, cmd_o.clr, cmd_o.wb}))

endmodule

// ===== rtl/cdfl_datapath.sv =====
// ----------------------------------------------------------------------------
// cdfl_datapath
// Flag store, merge logic, running totals and result register.
// ----------------------------------------------------------------------------
`include "code_data_flag_logger_macros.svh"

module cdfl_datapath #(
  parameter int ENTRIES = cdfl_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdfl_pkg::cdfl_cmd_t           cmd_i,
  output cdfl_pkg::cdfl_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic [cdfl_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic [cdfl_pkg::OP_W-1:0]     op_i,
  input  logic [cdfl_pkg::ADDR_W-1:0]   address_i,
  input  logic [cdfl_pkg::FLAG_W-1:0]   flags_i,
  output logic [cdfl_pkg::FLAG_W-1:0]   entry_flags_o,
  output logic                          is_code_o,
  output logic                          is_data_o,
  output logic                          is_jump_target_o,
  output logic                          is_sub_entry_o,
  output logic [cdfl_pkg::MODE_W-1:0]   cpu_mode_bits_o,
  output logic [cdfl_pkg::TOT_W-1:0]    code_total_o,
  output logic [cdfl_pkg::TOT_W-1:0]    data_total_o,
  output logic                          in_range_o
);
  import cdfl_pkg::*;

  localparam int AW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int CMP_W = ADDR_W + 1;
  localparam logic [CMP_W-1:0] ENT_LIM  = CMP_W'(ENTRIES);
  localparam logic [AW-1:0]    LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [CW:0]      SUM_LIM  = (CW + 1)'(ENTRIES);

  function automatic logic [FLAG_W-1:0] merge_flags(input logic [FLAG_W-1:0] old,
                                                    input logic [FLAG_W-1:0] f);
    logic [FLAG_W-1:0] res;
    res = old;
    if ((old & f) != f) begin
      if (f[FL_CODE_B]) begin
        res = f | (old & CODE_KEEP);
      end else if (f[FL_DATA_B]) begin
        if (!old[FL_CODE_B]) res = old | f;
      end else begin
        res = old | f;
      end
    end
    return res;
  endfunction

  logic [FLAG_W-1:0] store_mem [ENTRIES];

  logic [SIZE_W-1:0] rom_size_q;
  logic [AW-1:0]     clr_idx_q;
  logic [CW-1:0]     code_cnt_q, code_cnt_d;
  logic [CW-1:0]     data_cnt_q, data_cnt_d;

  logic [OP_W-1:0]   op_q;
  logic [AW-1:0]     addr_q;
  logic [FLAG_W-1:0] flags_q;
  logic              ok_q, ok_d;
  logic [FLAG_W-1:0] rdata_q;

  logic [FLAG_W-1:0] ent_q;
  logic [TOT_W-1:0]  code_tot_q, data_tot_q;
  logic              in_range_q;

  logic [FLAG_W-1:0] new_flags;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [FLAG_W-1:0] mem_wdata;
  logic [CMP_W-1:0]  addr_ext, size_ext;
  logic              upd;
  logic              old_code, old_data, new_code, new_data;
  logic [CW+TOT_W-1:0] code_ext, data_ext;
  logic [CW:0]       cnt_sum;

  assign addr_ext = CMP_W'(address_i);
  assign size_ext = CMP_W'(rom_size_q);
  assign ok_d     = (addr_ext < size_ext) && (addr_ext < ENT_LIM);

  always_comb begin
    case (op_q)
      OP_MERGE: new_flags = merge_flags(rdata_q, flags_q);
      OP_RAW:   new_flags = flags_q;
      default:  new_flags = rdata_q;
    endcase
  end

  assign old_code = rdata_q[FL_CODE_B];
  assign old_data = rdata_q[FL_DATA_B] && !rdata_q[FL_CODE_B];
  assign new_code = new_flags[FL_CODE_B];
  assign new_data = new_flags[FL_DATA_B] && !new_flags[FL_CODE_B];
  assign upd      = cmd_i.wb && ok_q;

  always_comb begin
    code_cnt_d = code_cnt_q;
    data_cnt_d = data_cnt_q;
    if (upd) begin
      code_cnt_d = code_cnt_q + CW'(new_code) - CW'(old_code);
      data_cnt_d = data_cnt_q + CW'(new_data) - CW'(old_data);
    end
  end

  assign code_ext = {{TOT_W{1'b0}}, code_cnt_d};
  assign data_ext = {{TOT_W{1'b0}}, data_cnt_d};

  assign mem_we    = cmd_i.clr || upd;
  assign mem_waddr = cmd_i.clr ? clr_idx_q : addr_q;
  assign mem_wdata = cmd_i.clr ? '0 : new_flags;

  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    if (cmd_i.rd) rdata_q <= store_mem[address_i[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_size_q <= ROM_SIZE_RST;
      clr_idx_q  <= '0;
      code_cnt_q <= '0;
      data_cnt_q <= '0;
    end else begin
      if (cfg_we_i) rom_size_q <= cfg_wdata_i;
      if (cmd_i.clr) clr_idx_q <= clr_idx_q + AW'(1);
      code_cnt_q <= code_cnt_d;
      data_cnt_q <= data_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      op_q    <= op_i;
      addr_q  <= address_i[AW-1:0];
      flags_q <= flags_i;
      ok_q    <= ok_d;
    end
    if (cmd_i.wb) begin
      ent_q      <= ok_q ? new_flags : '0;
      code_tot_q <= code_ext[TOT_W-1:0];
      data_tot_q <= data_ext[TOT_W-1:0];
      in_range_q <= ok_q;
    end
  end

  assign sts_o.clr_last = (clr_idx_q == LAST_IDX);

  assign entry_flags_o    = ent_q;
  assign is_code_o        = ent_q[FL_CODE_B];
  assign is_data_o        = ent_q[FL_DATA_B];
  assign is_jump_target_o = ent_q[FL_JUMP_B];
  assign is_sub_entry_o   = ent_q[FL_SUB_B];
  assign cpu_mode_bits_o  = {ent_q[FL_MEM8_B], ent_q[FL_IDX8_B]};
  assign code_total_o     = code_tot_q;
  assign data_total_o     = data_tot_q;
  assign in_range_o       = in_range_q;

  // code and data-only entries are disjoint, so together never exceed the store
  assign cnt_sum = {1'b0, code_cnt_q} + {1'b0, data_cnt_q};

  `CDFL_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_sum <= SUM_LIM)

endmodule

// ===== rtl/code_data_flag_logger.sv =====
// Each input is taken with a store read into rdata_q; the write-back then
// loads the result register and raises out_valid_o, so items do not overlap.
// A stalled result holds the write-back; no input is taken until it is done.
// Reset: rom_size returns to 65536 and a clearing pass zeroes the flag store,
// one entry per cycle, during which no input is taken.
// ----------------------------------------------------------------------------
// code_data_flag_logger
// Per-address flag byte store with flag merging and code/data totals.
// ----------------------------------------------------------------------------
module code_data_flag_logger #(
  parameter int ENTRIES = cdfl_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdfl_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cdfl_pkg::OP_W-1:0]     op_i,
  input  logic [cdfl_pkg::ADDR_W-1:0]   address_i,
  input  logic [cdfl_pkg::FLAG_W-1:0]   flags_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cdfl_pkg::FLAG_W-1:0]   entry_flags_o,
  output logic                          is_code_o,
  output logic                          is_data_o,
  output logic                          is_jump_target_o,
  output logic                          is_sub_entry_o,
  output logic [cdfl_pkg::MODE_W-1:0]   cpu_mode_bits_o,
  output logic [cdfl_pkg::TOT_W-1:0]    code_total_o,
  output logic [cdfl_pkg::TOT_W-1:0]    data_total_o,
  output logic                          in_range_o
);
  import cdfl_pkg::*;

  cdfl_cmd_t cmd;
  cdfl_sts_t sts;

  cdfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdfl_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .address_i        (address_i),
    .flags_i          (flags_i),
    .entry_flags_o    (entry_flags_o),
    .is_code_o        (is_code_o),
    .is_data_o        (is_data_o),
    .is_jump_target_o (is_jump_target_o),
    .is_sub_entry_o   (is_sub_entry_o),
    .cpu_mode_bits_o  (cpu_mode_bits_o),
    .code_total_o     (code_total_o),
    .data_total_o     (data_total_o),
    .in_range_o       (in_range_o)
  );

endmodule
